// ===== sv/qlta_pkg.sv =====
// Shared types and constants of the Q-learning table agent.
package qlta_pkg;

  localparam int unsigned StateW    = 8;
  localparam int unsigned ActW      = 3;
  localparam int unsigned NumStates = 256;
  localparam int unsigned NumActs   = 8;
  localparam int unsigned QW        = 24;
  localparam int unsigned GainW     = 16;
  localparam int unsigned RateW     = 17;
  localparam int unsigned RewW      = 16;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam logic [GainW-1:0] LearnReset = 16'd6554;
  localparam logic [GainW-1:0] DiscReset  = 16'd58982;
  localparam logic [RateW-1:0] StartReset = 17'd65536;
  localparam logic [GainW-1:0] DecayReset = 16'd64880;
  localparam logic [RateW-1:0] FloorReset = 17'd655;
  localparam logic [RateW-1:0] RateOne    = 17'd65536;

  typedef logic signed [QW-1:0] qval_t;
  typedef qval_t [NumActs-1:0] row_t;

  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_LEARN = 3'd0,
    REG_DISC  = 3'd1,
    REG_START = 3'd2,
    REG_DECAY = 3'd3,
    REG_FLOOR = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAX,
    S_CUR,
    S_TD,
    S_WB
  } state_e;

endpackage

// ===== sv/q_learning_table_agent_unit.sv =====
// Top level of the tabular Q-learning agent with epsilon-greedy choice.
//
// Requests arrive on the in_* channel (valid/stall) and each one yields a
// single result on the out_* channel. Opcode choose returns the exploring
// random action when random_uniform is below the exploration rate, else the
// first index of the row maximum; new_q_value carries that maximum. Opcode
// update applies q += lr*(reward + gamma*max(next row) - q) with saturation
// and then updates the exploration rate (reset to 1.0 on episode_done,
// decayed while above the floor).
// The table is one row-wide synchronous memory (256 rows of 8 entries) with
// a registered read; every item reads one or two rows through its single
// read port, and an update writes its row back after a two-multiply chain.
// A choose goes through S_MAX only; an update goes on through S_CUR, S_TD
// and S_WB. A new request is taken only when the block is back in S_IDLE,
// so requests do not overlap; the row reads and multiplies set the pace.
// Reset clears a per-row valid flag, so the whole table reads as zero at
// once; no clearing pass is needed. The result sits in an output register;
// while out_stall_i holds it, the next request may be accepted but does not
// complete until that result is taken.
// The user must write configuration through the APB port only while the block idles; the block does not enforce it.
module q_learning_table_agent_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [qlta_pkg::StateW-1:0]       cur_state_i,
  input  logic [qlta_pkg::ActW-1:0]         taken_action_i,
  input  logic signed [qlta_pkg::RewW-1:0]  reward_value_i,
  input  logic [qlta_pkg::StateW-1:0]       following_state_i,
  input  logic                              episode_done_i,
  input  logic [qlta_pkg::GainW-1:0]        random_uniform_i,
  input  logic [qlta_pkg::ActW-1:0]         random_action_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qlta_pkg::ActW-1:0]         chosen_action_o,
  output logic                              explored_o,
  output logic signed [qlta_pkg::QW-1:0]    new_q_value_o,
  output logic [qlta_pkg::RateW-1:0]        explore_rate_now_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qlta_pkg::AddrW-1:0]        paddr,
  input  logic [qlta_pkg::DataW-1:0]        pwdata,
  output logic [qlta_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import qlta_pkg::*;

  state_e state_q, state_d;

  logic [GainW-1:0] learn_q, disc_q, decay_q;
  logic [RateW-1:0] start_q, floor_q, rate_q;

  logic              op_q, done_q;
  logic [StateW-1:0] cur_q;
  logic [ActW-1:0]   act_q, ract_q;
  logic [RewW-1:0]   rew_q;
  logic [GainW-1:0]  rnd_q;

  row_t              mem [NumStates];
  row_t              rdata_q;
  logic              rvalid_q;
  logic [NumStates-1:0] row_valid_q;

  logic              rd_en, wr_en, finish, in_accept, out_free, cfg_wr;
  logic [StateW-1:0] rd_addr;
  row_t              row_cur, wr_row;

  qval_t             rmax;
  logic [ActW-1:0]   ridx;
  qval_t             nm_q, q_q;

  logic signed [40:0] prod_g_q, g_round;
  logic signed [24:0] g_val;
  logic signed [28:0] td;
  logic signed [45:0] prod_d_q, d_round;
  logic signed [29:0] d_val;
  logic signed [30:0] nq_wide;
  qval_t              nq_sat;

  logic [RateW-1:0]  rate_base, rate_next;
  logic [32:0]       rate_prod;
  logic              explore_hit;

  logic              out_valid_q, explored_q;
  logic [ActW-1:0]   chosen_q;
  qval_t             newq_q;
  logic [RateW-1:0]  rate_out_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  assign row_cur = rvalid_q ? rdata_q : '0;

  qlta_row_max u_row_max (
    .row_i (row_cur),
    .max_o (rmax),
    .idx_o (ridx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MAX;
      S_MAX: begin
        if (op_q == OP_UPDATE) begin
          state_d = S_CUR;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CUR: state_d = S_TD;
      S_TD:  state_d = S_WB;
      S_WB:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    finish     = 1'b0;
    wr_en      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
        rd_addr    = (opcode_i == OP_UPDATE) ? following_state_i : cur_state_i;
      end
      S_MAX: begin
        if (op_q == OP_UPDATE) begin
          rd_en = 1'b1;
        end else begin
          finish = out_free;
        end
      end
      S_WB: begin
        finish = out_free;
        wr_en  = out_free;
      end
      default: ;
    endcase
  end

  // update arithmetic and exploration compare
  always_comb begin
    g_round   = prod_g_q + 41'sd32768;
    g_val     = g_round[40:16];
    td        = $signed({rew_q[RewW-1], rew_q, 12'b0}) + 29'(g_val) - 29'(q_q);
    d_round   = prod_d_q + 46'sd32768;
    d_val     = d_round[45:16];
    nq_wide   = 31'(q_q) + 31'(d_val);
    if (nq_wide > 31'sd8388607) begin
      nq_sat = 24'sh7FFFFF;
    end else if (nq_wide < -31'sd8388608) begin
      nq_sat = 24'sh800000;
    end else begin
      nq_sat = nq_wide[QW-1:0];
    end
    wr_row        = row_cur;
    wr_row[act_q] = nq_sat;
    rate_base     = done_q ? RateOne : rate_q;
    rate_prod     = 33'(rate_base) * 33'(decay_q);
    rate_next     = (rate_base > floor_q) ? rate_prod[32:16] : rate_base;
    explore_hit   = {1'b0, rnd_q} < rate_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cur_q] <= wr_row;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      learn_q     <= LearnReset;
      disc_q      <= DiscReset;
      start_q     <= StartReset;
      decay_q     <= DecayReset;
      floor_q     <= FloorReset;
      rate_q      <= StartReset;
    end else begin
      state_q <= state_d;
      if (rd_en) rvalid_q <= row_valid_q[rd_addr];
      if (wr_en) row_valid_q[cur_q] <= 1'b1;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) rate_q <= rate_next;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_LEARN: learn_q <= pwdata[GainW-1:0];
          REG_DISC:  disc_q  <= pwdata[GainW-1:0];
          REG_START: begin
            start_q <= pwdata[RateW-1:0];
            rate_q  <= pwdata[RateW-1:0];
          end
          REG_DECAY: decay_q <= pwdata[GainW-1:0];
          REG_FLOOR: floor_q <= pwdata[RateW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      cur_q  <= cur_state_i;
      act_q  <= taken_action_i;
      rew_q  <= reward_value_i;
      done_q <= episode_done_i;
      rnd_q  <= random_uniform_i;
      ract_q <= random_action_i;
    end
    if (state_q == S_MAX) nm_q <= rmax;
    if (state_q == S_CUR) begin
      q_q      <= row_cur[act_q];
      prod_g_q <= 41'($signed({1'b0, disc_q})) * 41'(nm_q);
    end
    if (state_q == S_TD) prod_d_q <= 46'($signed({1'b0, learn_q})) * 46'(td);
    if (finish) begin
      if (state_q == S_WB) begin
        chosen_q   <= act_q;
        explored_q <= 1'b0;
        newq_q     <= nq_sat;
        rate_out_q <= rate_next;
      end else begin
        chosen_q   <= explore_hit ? ract_q : ridx;
        explored_q <= explore_hit;
        newq_q     <= rmax;
        rate_out_q <= rate_q;
      end
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LEARN: prdata = DataW'(learn_q);
      REG_DISC:  prdata = DataW'(disc_q);
      REG_START: prdata = DataW'(start_q);
      REG_DECAY: prdata = DataW'(decay_q);
      REG_FLOOR: prdata = DataW'(floor_q);
      default:   prdata = '0;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign chosen_action_o    = chosen_q;
  assign explored_o         = explored_q;
  assign new_q_value_o      = newq_q;
  assign explore_rate_now_o = rate_out_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_MAX)
    else $error("accepted request did not start a row read");

  a_write_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_WB && op_q == OP_UPDATE)
    else $error("table write outside write-back");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> row_valid_q[$past(cur_q)])
    else $error("written row not marked valid");

  a_finish_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q && state_q == S_IDLE)
    else $error("finished request did not reach the output register");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("request taken while busy");

endmodule

// ===== sv/qlta_row_max.sv =====
// Row maximum with first-index tie break, three-level compare tree.
module qlta_row_max (
  input  qlta_pkg::row_t                row_i,
  output qlta_pkg::qval_t               max_o,
  output logic [qlta_pkg::ActW-1:0]     idx_o
);
  import qlta_pkg::*;

  qval_t           l1_val [4];
  logic [ActW-1:0] l1_idx [4];
  qval_t           l2_val [2];
  logic [ActW-1:0] l2_idx [2];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (row_i[2*i+1] > row_i[2*i]) begin
        l1_val[i] = row_i[2*i+1];
        l1_idx[i] = ActW'(2*i+1);
      end else begin
        l1_val[i] = row_i[2*i];
        l1_idx[i] = ActW'(2*i);
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (l1_val[2*j+1] > l1_val[2*j]) begin
        l2_val[j] = l1_val[2*j+1];
        l2_idx[j] = l1_idx[2*j+1];
      end else begin
        l2_val[j] = l1_val[2*j];
        l2_idx[j] = l1_idx[2*j];
      end
    end
    if (l2_val[1] > l2_val[0]) begin
      max_o = l2_val[1];
      idx_o = l2_idx[1];
    end else begin
      max_o = l2_val[0];
      idx_o = l2_idx[0];
    end
  end

endmodule
